### sv/tdg_pkg.sv
// shared types and constants of the tile dma descriptor generator
package tdg_pkg;

    // plane padding in words and smallest residual tile
    localparam int PLANE_PAD_WORDS   = 256;
    localparam int MIN_RESIDUAL_ROWS = 6;

    // field widths
    localparam int GEOM_W  = 10;
    localparam int COUNT_W = 8;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 24;
    localparam int SIZE_W  = 2 * GEOM_W;

    // remainder unit steps, one dividend bit each
    localparam int DIV_STEPS = GEOM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_COLS     = 3'd0;
    localparam logic [2:0] CFG_FRAME_ROWS     = 3'd1;
    localparam logic [2:0] CFG_TILE_ROWS      = 3'd2;
    localparam logic [2:0] CFG_TILE_COUNT     = 3'd3;
    localparam logic [2:0] CFG_CHANNEL_GROUPS = 3'd4;
    localparam logic [2:0] CFG_HALF_OUTPUT    = 3'd5;
    localparam logic [2:0] CFG_INPUT_BASE     = 3'd6;
    localparam logic [2:0] CFG_OUTPUT_BASE    = 3'd7;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_R_SIZE,
        ST_R_BASE,
        ST_R_PRE,
        ST_R_OFF,
        ST_R_LEN,
        ST_S_SIZE,
        ST_S_BASE,
        ST_S_PRE,
        ST_S_OFF,
        ST_S_LEN,
        ST_FINISH,
        ST_OUT
    } state_t;

    // one operation of the multiply-add unit: a * b + add, low 32 bits
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [GEOM_W-1:0] b;
        logic [ADDR_W-1:0] add;
    } mac_op_t;

    // remainder unit status
    typedef struct packed {
        logic              busy;
        logic [GEOM_W-1:0] remainder;
    } div_status_t;

endpackage

### sv/tdg_mac.sv
// shared multiply-add unit with registered result
module tdg_mac (
    input  logic                          clk,
    input  tdg_pkg::mac_op_t              op,
    output logic [tdg_pkg::ADDR_W-1:0]    result
);

    logic [tdg_pkg::ADDR_W+tdg_pkg::GEOM_W-1:0] prod;
    logic [tdg_pkg::ADDR_W-1:0]                 result_reg;
    logic [tdg_pkg::ADDR_W-1:0]                 result_next;

    // product kept modulo 2^32
    always_comb
    begin
        prod        = {{tdg_pkg::GEOM_W{1'b0}}, op.a} * {{tdg_pkg::ADDR_W{1'b0}}, op.b};
        result_next = prod[tdg_pkg::ADDR_W-1:0] + op.add;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### sv/tdg_remainder.sv
// restoring remainder unit, one dividend bit per cycle
module tdg_remainder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tdg_pkg::GEOM_W-1:0]    dividend,
    input  logic [tdg_pkg::GEOM_W-1:0]    divisor,
    output tdg_pkg::div_status_t          status
);

    logic [tdg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [tdg_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [tdg_pkg::GEOM_W-1:0]    rem_reg;
    logic [tdg_pkg::GEOM_W-1:0]    rem_next;
    logic [tdg_pkg::GEOM_W-1:0]    quo_reg;
    logic [tdg_pkg::GEOM_W-1:0]    quo_next;
    logic [tdg_pkg::GEOM_W:0]      trial;
    logic [tdg_pkg::GEOM_W:0]      diff;

    // shift in the next dividend bit and subtract when it fits
    // a zero divisor always fits, so the remainder ends as the dividend
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = {rem_reg, quo_reg[tdg_pkg::GEOM_W-1]};
        diff     = trial - {1'b0, divisor};
        if (start)
        begin
            cnt_next = tdg_pkg::DIV_CNT_W'(tdg_pkg::DIV_STEPS);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[tdg_pkg::GEOM_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[tdg_pkg::GEOM_W-1:0];
            end
            else
            begin
                rem_next = trial[tdg_pkg::GEOM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.busy      = (cnt_reg != '0);
    assign status.remainder = rem_reg;

endmodule

### sv/tile_dma_descriptor_generator.sv
// tile dma descriptor generator: loop walker and descriptor sequencer
// a remainder phase, then one shared multiply-add per cycle (10 steps, 5 on a restart)
// and a finishing state build each descriptor
// one item at a time: the next task is taken the cycle after the descriptor transfer;
// reset (rst_n, async, active low) zeroes positions
module tile_dma_descriptor_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    // task channel
    input  logic                          job_valid,
    output logic                          job_stall,
    input  logic                          restart,
    // descriptor channel
    output logic                          desc_valid,
    input  logic                          desc_stall,
    output logic                          recv_active,
    output logic [tdg_pkg::ADDR_W-1:0]    recv_address,
    output logic [tdg_pkg::LEN_W-1:0]     recv_length,
    output logic                          send_active,
    output logic [tdg_pkg::ADDR_W-1:0]    send_address,
    output logic [tdg_pkg::LEN_W-1:0]     send_length,
    output logic                          last_task
);

    localparam int GW = tdg_pkg::GEOM_W;
    localparam int CW = tdg_pkg::COUNT_W;
    localparam int AW = tdg_pkg::ADDR_W;
    localparam int LW = tdg_pkg::LEN_W;
    localparam int SW = tdg_pkg::SIZE_W;

    tdg_pkg::state_t state_reg, state_next;

    // configuration
    logic [GW-1:0] frame_cols_reg, frame_cols_next;
    logic [GW-1:0] frame_rows_reg, frame_rows_next;
    logic [GW-1:0] tile_rows_reg, tile_rows_next;
    logic [CW-1:0] tile_count_reg, tile_count_next;
    logic [15:0]   channel_groups_reg, channel_groups_next;
    logic          half_output_reg, half_output_next;
    logic [AW-1:0] input_base_reg, input_base_next;
    logic [AW-1:0] output_base_reg, output_base_next;

    // loop positions
    logic [CW-1:0] pre_in_group_reg, pre_in_group_next;
    logic [CW-1:0] pre_tile_reg, pre_tile_next;
    logic [CW-1:0] pre_out_group_reg, pre_out_group_next;
    logic [CW-1:0] post_in_group_reg, post_in_group_next;
    logic [CW-1:0] post_tile_reg, post_tile_next;
    logic [CW-1:0] post_out_group_reg, post_out_group_next;
    logic          restart_reg, restart_next;

    // working values and result registers
    logic [GW-1:0] resid_reg, resid_next;
    logic [SW-1:0] size_reg, size_next;
    logic [AW-1:0] base_reg, base_next;
    logic          recv_active_reg, recv_active_next;
    logic [AW-1:0] recv_address_reg, recv_address_next;
    logic [LW-1:0] recv_length_reg, recv_length_next;
    logic          send_active_reg, send_active_next;
    logic [AW-1:0] send_address_reg, send_address_next;
    logic [LW-1:0] send_length_reg, send_length_next;
    logic          last_task_reg, last_task_next;

    tdg_pkg::mac_op_t     mac_op;
    logic [AW-1:0]        mac_res;
    tdg_pkg::div_status_t div_status;

    logic          cfg_write;
    logic          task_accept;
    logic          desc_accept;
    logic          div_start;
    logic [CW-1:0] in_last;
    logic [CW-1:0] tile_last;
    logic [CW-1:0] out_last;
    logic          single_tile;
    logic          post_final;
    logic          recv_on;
    logic [GW-1:0] rc, rr, rd, re;
    logic [GW-1:0] resid_raw;
    logic [AW-1:0] mac_pad;
    logic [CW-1:0] in_group_inc;
    logic [CW-1:0] tile_inc;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign task_accept = job_valid && !job_stall;
    assign desc_accept = desc_valid && !desc_stall;

    // loop limits, a count of zero acts as 256
    assign in_last     = channel_groups_reg[7:0] - 1'b1;
    assign out_last    = channel_groups_reg[15:8] - 1'b1;
    assign tile_last   = tile_count_reg - 1'b1;
    assign single_tile = (tile_count_reg == CW'(1));
    assign post_final  = (post_out_group_reg == out_last) && (post_tile_reg == tile_last)
                         && (post_in_group_reg == in_last);
    assign recv_on     = (post_in_group_reg == in_last);

    // output geometry, halved under stride-2 pooling
    always_comb
    begin
        if (half_output_reg)
        begin
            rc = {1'b0, frame_cols_reg[GW-1:1]} + 1'b1;
            rr = {1'b0, frame_rows_reg[GW-1:1]} + 1'b1;
            rd = {1'b0, tile_rows_reg[GW-1:1]};
            re = {1'b0, resid_reg[GW-1:1]};
        end
        else
        begin
            rc = frame_cols_reg;
            rr = frame_rows_reg;
            rd = tile_rows_reg;
            re = resid_reg;
        end
    end

    // plane start: padded when a plane is small
    assign mac_pad = (mac_res > AW'(tdg_pkg::PLANE_PAD_WORDS)) ? mac_res
                                                               : AW'(tdg_pkg::PLANE_PAD_WORDS);

    // shared units
    tdg_mac u_mac (
        .clk    (clk),
        .op     (mac_op),
        .result (mac_res)
    );

    tdg_remainder u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (frame_rows_reg),
        .divisor  (tile_rows_reg),
        .status   (div_status)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdg_pkg::ST_IDLE:
            begin
                if (task_accept)
                begin
                    state_next = tdg_pkg::ST_DIV;
                end
            end
            tdg_pkg::ST_DIV:
            begin
                if (!div_status.busy)
                begin
                    state_next = restart_reg ? tdg_pkg::ST_S_SIZE : tdg_pkg::ST_R_SIZE;
                end
            end
            tdg_pkg::ST_R_SIZE: state_next = tdg_pkg::ST_R_BASE;
            tdg_pkg::ST_R_BASE: state_next = tdg_pkg::ST_R_PRE;
            tdg_pkg::ST_R_PRE:  state_next = tdg_pkg::ST_R_OFF;
            tdg_pkg::ST_R_OFF:  state_next = tdg_pkg::ST_R_LEN;
            tdg_pkg::ST_R_LEN:  state_next = tdg_pkg::ST_S_SIZE;
            tdg_pkg::ST_S_SIZE: state_next = tdg_pkg::ST_S_BASE;
            tdg_pkg::ST_S_BASE: state_next = tdg_pkg::ST_S_PRE;
            tdg_pkg::ST_S_PRE:  state_next = tdg_pkg::ST_S_OFF;
            tdg_pkg::ST_S_OFF:  state_next = tdg_pkg::ST_S_LEN;
            tdg_pkg::ST_S_LEN:  state_next = tdg_pkg::ST_FINISH;
            tdg_pkg::ST_FINISH: state_next = tdg_pkg::ST_OUT;
            tdg_pkg::ST_OUT:
            begin
                if (desc_accept)
                begin
                    state_next = tdg_pkg::ST_IDLE;
                end
            end
            default: state_next = tdg_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        job_stall  = (state_reg != tdg_pkg::ST_IDLE);
        desc_valid = (state_reg == tdg_pkg::ST_OUT);
        div_start  = task_accept;
    end

    // multiply-add operation per step
    always_comb
    begin
        mac_op = '0;
        case (state_reg)
            tdg_pkg::ST_R_SIZE:
            begin
                mac_op.a = AW'(rr);
                mac_op.b = rc;
            end
            tdg_pkg::ST_R_BASE:
            begin
                mac_op.a = mac_pad;
                mac_op.b = GW'(post_out_group_reg);
            end
            tdg_pkg::ST_R_PRE:
            begin
                mac_op.a = AW'(post_tile_reg);
                mac_op.b = rd;
            end
            tdg_pkg::ST_R_OFF:
            begin
                if (single_tile || (post_tile_reg == '0))
                begin
                    mac_op.add = base_reg;
                end
                else if (post_tile_reg == tile_last)
                begin
                    mac_op.a   = AW'(rr) - AW'(re) - AW'(1);
                    mac_op.b   = rc;
                    mac_op.add = base_reg;
                end
                else
                begin
                    // (tile * rows + 1) * cols
                    mac_op.a   = mac_res;
                    mac_op.b   = rc;
                    mac_op.add = base_reg + AW'(rc);
                end
            end
            tdg_pkg::ST_R_LEN:
            begin
                if (single_tile)
                begin
                    mac_op.add = AW'(size_reg);
                end
                else if (post_tile_reg == '0)
                begin
                    mac_op.a = AW'(rd) + AW'(1);
                    mac_op.b = rc;
                end
                else if (post_tile_reg == tile_last)
                begin
                    mac_op.a = AW'(re) + AW'(1);
                    mac_op.b = rc;
                end
                else
                begin
                    mac_op.a = AW'(rd);
                    mac_op.b = rc;
                end
            end
            tdg_pkg::ST_S_SIZE:
            begin
                mac_op.a = AW'(frame_rows_reg);
                mac_op.b = frame_cols_reg;
            end
            tdg_pkg::ST_S_BASE:
            begin
                mac_op.a = mac_pad;
                mac_op.b = GW'(pre_in_group_reg);
            end
            tdg_pkg::ST_S_PRE:
            begin
                mac_op.a = AW'(pre_tile_reg);
                mac_op.b = tile_rows_reg;
            end
            tdg_pkg::ST_S_OFF:
            begin
                if (single_tile)
                begin
                    mac_op.add = base_reg;
                end
                else if (pre_tile_reg == tile_last)
                begin
                    // last tile ends on the last row, two halo rows above
                    mac_op.a   = AW'(frame_rows_reg) - AW'(resid_reg) - AW'(2);
                    mac_op.b   = frame_cols_reg;
                    mac_op.add = base_reg;
                end
                else
                begin
                    mac_op.a   = mac_res;
                    mac_op.b   = frame_cols_reg;
                    mac_op.add = base_reg;
                end
            end
            tdg_pkg::ST_S_LEN:
            begin
                if (single_tile)
                begin
                    mac_op.add = AW'(size_reg);
                end
                else if (pre_tile_reg == tile_last)
                begin
                    mac_op.a = AW'(resid_reg) + AW'(2);
                    mac_op.b = frame_cols_reg;
                end
                else
                begin
                    mac_op.a = AW'(tile_rows_reg) + AW'(2);
                    mac_op.b = frame_cols_reg;
                end
            end
            default: mac_op = '0;
        endcase
    end

    // residual rows from the remainder
    always_comb
    begin
        resid_raw = (div_status.remainder == '0) ? tile_rows_reg : div_status.remainder;
        if (resid_raw < GW'(tdg_pkg::MIN_RESIDUAL_ROWS))
        begin
            resid_raw = GW'(tdg_pkg::MIN_RESIDUAL_ROWS);
        end
    end

    assign in_group_inc = pre_in_group_reg + 1'b1;
    assign tile_inc     = pre_tile_reg + 1'b1;

    // configuration, positions and datapath next values
    always_comb
    begin
        frame_cols_next     = frame_cols_reg;
        frame_rows_next     = frame_rows_reg;
        tile_rows_next      = tile_rows_reg;
        tile_count_next     = tile_count_reg;
        channel_groups_next = channel_groups_reg;
        half_output_next    = half_output_reg;
        input_base_next     = input_base_reg;
        output_base_next    = output_base_reg;
        pre_in_group_next   = pre_in_group_reg;
        pre_tile_next       = pre_tile_reg;
        pre_out_group_next  = pre_out_group_reg;
        post_in_group_next  = post_in_group_reg;
        post_tile_next      = post_tile_reg;
        post_out_group_next = post_out_group_reg;
        restart_next        = restart_reg;
        resid_next          = resid_reg;
        size_next           = size_reg;
        base_next           = base_reg;
        recv_active_next    = recv_active_reg;
        recv_address_next   = recv_address_reg;
        recv_length_next    = recv_length_reg;
        send_active_next    = send_active_reg;
        send_address_next   = send_address_reg;
        send_length_next    = send_length_reg;
        last_task_next      = last_task_reg;

        // register writes
        if (cfg_write)
        begin
            case (cfg_index)
                tdg_pkg::CFG_FRAME_COLS:     frame_cols_next     = cfg_data[GW-1:0];
                tdg_pkg::CFG_FRAME_ROWS:     frame_rows_next     = cfg_data[GW-1:0];
                tdg_pkg::CFG_TILE_ROWS:      tile_rows_next      = cfg_data[GW-1:0];
                tdg_pkg::CFG_TILE_COUNT:     tile_count_next     = cfg_data[CW-1:0];
                tdg_pkg::CFG_CHANNEL_GROUPS: channel_groups_next = cfg_data[15:0];
                tdg_pkg::CFG_HALF_OUTPUT:    half_output_next    = cfg_data[0];
                tdg_pkg::CFG_INPUT_BASE:     input_base_next     = cfg_data;
                tdg_pkg::CFG_OUTPUT_BASE:    output_base_next    = cfg_data;
                default:                     frame_cols_next     = frame_cols_reg;
            endcase
        end

        case (state_reg)
            tdg_pkg::ST_IDLE:
            begin
                if (task_accept)
                begin
                    restart_next = restart;
                    if (restart)
                    begin
                        pre_in_group_next   = '0;
                        pre_tile_next       = '0;
                        pre_out_group_next  = '0;
                        post_in_group_next  = '0;
                        post_tile_next      = '0;
                        post_out_group_next = '0;
                        recv_active_next    = 1'b0;
                        recv_address_next   = '0;
                        recv_length_next    = '0;
                        last_task_next      = 1'b0;
                    end
                end
            end
            tdg_pkg::ST_DIV:
            begin
                resid_next = resid_raw;
            end
            tdg_pkg::ST_R_BASE:
            begin
                size_next = mac_res[SW-1:0];
            end
            tdg_pkg::ST_R_PRE:
            begin
                base_next = mac_res;
            end
            tdg_pkg::ST_R_LEN:
            begin
                recv_address_next = output_base_reg + {mac_res[AW-4:0], 3'b000};
            end
            tdg_pkg::ST_S_SIZE:
            begin
                if (!restart_reg)
                begin
                    // receive fields and final flag from the finished position
                    recv_active_next = recv_on;
                    recv_length_next = recv_on ? {mac_res[LW-4:0], 3'b000} : '0;
                    if (!recv_on)
                    begin
                        recv_address_next = '0;
                    end
                    last_task_next = post_final;
                    // advance the loop: post takes pre, pre steps on
                    post_in_group_next  = pre_in_group_reg;
                    post_tile_next      = pre_tile_reg;
                    post_out_group_next = pre_out_group_reg;
                    pre_in_group_next   = in_group_inc;
                    if (in_group_inc == channel_groups_reg[7:0])
                    begin
                        pre_in_group_next = '0;
                        pre_tile_next     = tile_inc;
                        if (tile_inc == tile_count_reg)
                        begin
                            pre_tile_next      = '0;
                            pre_out_group_next = pre_out_group_reg + 1'b1;
                        end
                    end
                end
            end
            tdg_pkg::ST_S_BASE:
            begin
                size_next = mac_res[SW-1:0];
            end
            tdg_pkg::ST_S_PRE:
            begin
                base_next = mac_res;
            end
            tdg_pkg::ST_S_LEN:
            begin
                send_address_next = input_base_reg + {mac_res[AW-4:0], 3'b000};
            end
            tdg_pkg::ST_FINISH:
            begin
                // nothing to prefetch once the final task is current
                send_active_next = !post_final;
                send_length_next = {mac_res[LW-4:0], 3'b000};
                if (post_final)
                begin
                    send_address_next = '0;
                    send_length_next  = '0;
                end
            end
            default:
            begin
                restart_next = restart_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= tdg_pkg::ST_IDLE;
            frame_cols_reg     <= GW'(16);
            frame_rows_reg     <= GW'(16);
            tile_rows_reg      <= GW'(16);
            tile_count_reg     <= CW'(1);
            channel_groups_reg <= 16'd257;
            half_output_reg    <= 1'b0;
            input_base_reg     <= '0;
            output_base_reg    <= '0;
            pre_in_group_reg   <= '0;
            pre_tile_reg       <= '0;
            pre_out_group_reg  <= '0;
            post_in_group_reg  <= '0;
            post_tile_reg      <= '0;
            post_out_group_reg <= '0;
            restart_reg        <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            frame_cols_reg     <= frame_cols_next;
            frame_rows_reg     <= frame_rows_next;
            tile_rows_reg      <= tile_rows_next;
            tile_count_reg     <= tile_count_next;
            channel_groups_reg <= channel_groups_next;
            half_output_reg    <= half_output_next;
            input_base_reg     <= input_base_next;
            output_base_reg    <= output_base_next;
            pre_in_group_reg   <= pre_in_group_next;
            pre_tile_reg       <= pre_tile_next;
            pre_out_group_reg  <= pre_out_group_next;
            post_in_group_reg  <= post_in_group_next;
            post_tile_reg      <= post_tile_next;
            post_out_group_reg <= post_out_group_next;
            restart_reg        <= restart_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        resid_reg        <= resid_next;
        size_reg         <= size_next;
        base_reg         <= base_next;
        recv_active_reg  <= recv_active_next;
        recv_address_reg <= recv_address_next;
        recv_length_reg  <= recv_length_next;
        send_active_reg  <= send_active_next;
        send_address_reg <= send_address_next;
        send_length_reg  <= send_length_next;
        last_task_reg    <= last_task_next;
    end

    assign recv_active  = recv_active_reg;
    assign recv_address = recv_address_reg;
    assign recv_length  = recv_length_reg;
    assign send_active  = send_active_reg;
    assign send_address = send_address_reg;
    assign send_length  = send_length_reg;
    assign last_task    = last_task_reg;

endmodule

### sv/tdg_checker.sv
// port-level checks of the descriptor generator and their binding
module tdg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          job_valid,
    input logic                          job_stall,
    input logic                          desc_valid,
    input logic                          desc_stall,
    input logic                          recv_active,
    input logic [tdg_pkg::ADDR_W-1:0]    recv_address,
    input logic [tdg_pkg::LEN_W-1:0]     recv_length,
    input logic                          send_active,
    input logic [tdg_pkg::ADDR_W-1:0]    send_address,
    input logic [tdg_pkg::LEN_W-1:0]     send_length,
    input logic                          last_task
);

    // a stalled descriptor holds
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && desc_stall |=> desc_valid && $stable(send_address)
            && $stable(recv_address) && $stable(last_task))
        else $error("stalled descriptor changed");

    // a task transfer makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_stall |=> job_stall && !desc_valid)
        else $error("block not busy after task transfer");

    // no new task while a descriptor waits
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> job_stall)
        else $error("task taken while descriptor pending");

    // disabled descriptors carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && (!recv_active || !send_active) |->
            (recv_active || (recv_address == '0 && recv_length == '0))
            && (send_active || (send_address == '0 && send_length == '0)))
        else $error("disabled descriptor has nonzero fields");

    // the final task always receives its output tile
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && last_task |-> recv_active)
        else $error("last task without receive");

endmodule

bind tile_dma_descriptor_generator tdg_checker u_tdg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_stall    (job_stall),
    .desc_valid   (desc_valid),
    .desc_stall   (desc_stall),
    .recv_active  (recv_active),
    .recv_address (recv_address),
    .recv_length  (recv_length),
    .send_active  (send_active),
    .send_address (send_address),
    .send_length  (send_length),
    .last_task    (last_task)
);

### dv/tb_tile_dma_descriptor_generator.sv
// self-checking testbench of the tile dma descriptor generator
module tb_tile_dma_descriptor_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASK_TARGET  = 700;
    localparam int QUIET_TAIL   = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int LAYER_CAP    = 40;

    // one descriptor transfer as seen on the result channel
    typedef struct {
        logic                       recv_active;
        logic [tdg_pkg::ADDR_W-1:0] recv_address;
        logic [tdg_pkg::LEN_W-1:0]  recv_length;
        logic                       send_active;
        logic [tdg_pkg::ADDR_W-1:0] send_address;
        logic [tdg_pkg::LEN_W-1:0]  send_length;
        logic                       last_task;
    } descriptor_t;

    // one full set of layer registers
    typedef struct {
        bit [tdg_pkg::GEOM_W-1:0]  cols;
        bit [tdg_pkg::GEOM_W-1:0]  rows;
        bit [tdg_pkg::GEOM_W-1:0]  trows;
        bit [tdg_pkg::COUNT_W-1:0] tiles;
        bit [15:0]                 groups;
        bit                        halve;
        bit [tdg_pkg::ADDR_W-1:0]  in_base;
        bit [tdg_pkg::ADDR_W-1:0]  out_base;
    } layer_cfg_t;

    // loop walker mirror: tracks positions and predicts each descriptor
    class descriptor_checker;
        bit [tdg_pkg::GEOM_W-1:0]  cols, rows, trows;
        bit [tdg_pkg::COUNT_W-1:0] tiles;
        bit [15:0]                 groups;
        bit                        halve;
        bit [tdg_pkg::ADDR_W-1:0]  in_base, out_base;
        bit [tdg_pkg::COUNT_W-1:0] pre_ig, pre_tl, pre_og;
        bit [tdg_pkg::COUNT_W-1:0] post_ig, post_tl, post_og;
        descriptor_t               pending_descs[$];
        int                        errors;
        int                        checked;
        int                        recv_seen;
        int                        last_seen;

        function new();
            cols = 16; rows = 16; trows = 16; tiles = 1;
            groups = 16'd257; halve = 0; in_base = 0; out_base = 0;
            pre_ig = 0; pre_tl = 0; pre_og = 0;
            post_ig = 0; post_tl = 0; post_og = 0;
            errors = 0; checked = 0; recv_seen = 0; last_seen = 0;
        endfunction

        function void write_reg(bit [2:0] idx, bit [31:0] val);
            case (idx)
                tdg_pkg::CFG_FRAME_COLS:     cols = val[tdg_pkg::GEOM_W-1:0];
                tdg_pkg::CFG_FRAME_ROWS:     rows = val[tdg_pkg::GEOM_W-1:0];
                tdg_pkg::CFG_TILE_ROWS:      trows = val[tdg_pkg::GEOM_W-1:0];
                tdg_pkg::CFG_TILE_COUNT:     tiles = val[tdg_pkg::COUNT_W-1:0];
                tdg_pkg::CFG_CHANNEL_GROUPS: groups = val[15:0];
                tdg_pkg::CFG_HALF_OUTPUT:    halve = val[0];
                tdg_pkg::CFG_INPUT_BASE:     in_base = val;
                tdg_pkg::CFG_OUTPUT_BASE:    out_base = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_descs.size();
        endfunction

        // a count of zero wraps and acts as 256
        function bit [tdg_pkg::COUNT_W-1:0] last_of(bit [tdg_pkg::COUNT_W-1:0] n);
            bit [tdg_pkg::COUNT_W-1:0] m;
            m = n - 8'd1;
            return m;
        endfunction

        // rows of the bottom tile, never fewer than the minimum
        function bit [63:0] residual_rows();
            bit [63:0] e;
            if (trows == 0)
                e = rows;
            else
                e = rows % trows;
            if (e == 0)
                e = trows;
            if (e < tdg_pkg::MIN_RESIDUAL_ROWS)
                e = tdg_pkg::MIN_RESIDUAL_ROWS;
            return e;
        endfunction

        // small planes are padded out to a fixed stride
        function bit [63:0] plane_start(bit [63:0] grp, bit [63:0] size);
            if (size > tdg_pkg::PLANE_PAD_WORDS)
                return grp * size;
            return grp * tdg_pkg::PLANE_PAD_WORDS;
        endfunction

        function bit at_final();
            return post_og == last_of(groups[15:8]) && post_tl == last_of(tiles) &&
                   post_ig == last_of(groups[7:0]);
        endfunction

        // input tile for the prefetch position, two halo rows
        function void fill_send(inout descriptor_t d);
            bit [63:0] c, r, h, e, size, off, len;
            c = cols; r = rows; h = trows;
            size = c * r;
            if (at_final())
            begin
                d.send_active = 0; d.send_address = 0; d.send_length = 0;
                return;
            end
            if (tiles == 1)
            begin
                off = 0;
                len = size << 3;
            end
            else if (pre_tl == last_of(tiles))
            begin
                e = residual_rows();
                off = (r - e - 2) * c;
                len = ((e + 2) * c) << 3;
            end
            else
            begin
                off = pre_tl * h * c;
                len = ((h + 2) * c) << 3;
            end
            d.send_active = 1;
            d.send_address = in_base + ((plane_start(pre_ig, size) + off) << 3);
            d.send_length = len[tdg_pkg::LEN_W-1:0];
        endfunction

        // output tile for the finished position, on its last input group only
        function void fill_recv(inout descriptor_t d);
            bit [63:0] c, r, h, e, size, off, len;
            if (post_ig != last_of(groups[7:0]))
            begin
                d.recv_active = 0; d.recv_address = 0; d.recv_length = 0;
                return;
            end
            c = cols; r = rows; h = trows; e = residual_rows();
            if (halve)
            begin
                c = c / 2 + 1; r = r / 2 + 1; h = h >> 1; e = e >> 1;
            end
            size = c * r;
            if (tiles == 1)
            begin
                off = 0;
                len = size << 3;
            end
            else if (post_tl == 0)
            begin
                off = 0;
                len = ((h + 1) * c) << 3;
            end
            else if (post_tl == last_of(tiles))
            begin
                off = (r - e - 1) * c;
                len = ((e + 1) * c) << 3;
            end
            else
            begin
                off = (post_tl * h + 1) * c;
                len = (h * c) << 3;
            end
            d.recv_active = 1;
            d.recv_address = out_base + ((plane_start(post_og, size) + off) << 3);
            d.recv_length = len[tdg_pkg::LEN_W-1:0];
        endfunction

        // post takes pre, pre steps through groups, tiles, output groups
        function void step_loop();
            post_ig = pre_ig; post_tl = pre_tl; post_og = pre_og;
            pre_ig = pre_ig + 8'd1;
            if (pre_ig == groups[7:0])
            begin
                pre_ig = 0;
                pre_tl = pre_tl + 8'd1;
                if (pre_tl == tiles)
                begin
                    pre_tl = 0;
                    pre_og = pre_og + 8'd1;
                end
            end
        endfunction

        // accepted task transfer: predict its descriptor
        function void take_task(bit rs);
            descriptor_t d;
            d = '{default: 0};
            if (rs)
            begin
                pre_ig = 0; pre_tl = 0; pre_og = 0;
                post_ig = 0; post_tl = 0; post_og = 0;
            end
            else
            begin
                fill_recv(d);
                d.last_task = at_final();
                step_loop();
            end
            fill_send(d);
            pending_descs.push_back(d);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_descriptor(descriptor_t got);
            descriptor_t want;
            if (pending_descs.size() == 0)
            begin
                report("descriptor transfer with nothing outstanding");
                return;
            end
            want = pending_descs.pop_front();
            checked++;
            if (want.recv_active) recv_seen++;
            if (want.last_task) last_seen++;
            if (got.recv_active !== want.recv_active)
                report($sformatf("#%0d recv_active %b, wanted %b", checked,
                    got.recv_active, want.recv_active));
            if (got.recv_address !== want.recv_address)
                report($sformatf("#%0d recv_address %h, wanted %h", checked,
                    got.recv_address, want.recv_address));
            if (got.recv_length !== want.recv_length)
                report($sformatf("#%0d recv_length %h, wanted %h", checked,
                    got.recv_length, want.recv_length));
            if (got.send_active !== want.send_active)
                report($sformatf("#%0d send_active %b, wanted %b", checked,
                    got.send_active, want.send_active));
            if (got.send_address !== want.send_address)
                report($sformatf("#%0d send_address %h, wanted %h", checked,
                    got.send_address, want.send_address));
            if (got.send_length !== want.send_length)
                report($sformatf("#%0d send_length %h, wanted %h", checked,
                    got.send_length, want.send_length));
            if (got.last_task !== want.last_task)
                report($sformatf("#%0d last_task %b, wanted %b", checked,
                    got.last_task, want.last_task));
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [2:0]                 cfg_index = tdg_pkg::CFG_FRAME_COLS;
    logic [31:0]                cfg_data = '0;
    logic                       job_valid = 1'b0;
    logic                       job_stall;
    logic                       restart = 1'b0;
    logic                       desc_valid;
    logic                       desc_stall = 1'b0;
    logic                       recv_active;
    logic [tdg_pkg::ADDR_W-1:0] recv_address;
    logic [tdg_pkg::LEN_W-1:0]  recv_length;
    logic                       send_active;
    logic [tdg_pkg::ADDR_W-1:0] send_address;
    logic [tdg_pkg::LEN_W-1:0]  send_length;
    logic                       last_task;

    descriptor_checker checker_h = new();
    int tasks_sent = 0;
    int restarts_sent = 0;
    int layers_loaded = 0;
    bit bursts_on = 1'b0;
    bit quiet = 1'b0;

    tile_dma_descriptor_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .restart      (restart),
        .desc_valid   (desc_valid),
        .desc_stall   (desc_stall),
        .recv_active  (recv_active),
        .recv_address (recv_address),
        .recv_length  (recv_length),
        .send_active  (send_active),
        .send_address (send_address),
        .send_length  (send_length),
        .last_task    (last_task)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // register write, valid stays up for back-to-back writes
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        checker_h.write_reg(idx, val);
    endtask

    task automatic load_layer(input layer_cfg_t c);
        write_reg(tdg_pkg::CFG_FRAME_COLS, 32'(c.cols));
        write_reg(tdg_pkg::CFG_FRAME_ROWS, 32'(c.rows));
        write_reg(tdg_pkg::CFG_TILE_ROWS, 32'(c.trows));
        write_reg(tdg_pkg::CFG_TILE_COUNT, 32'(c.tiles));
        write_reg(tdg_pkg::CFG_CHANNEL_GROUPS, 32'(c.groups));
        write_reg(tdg_pkg::CFG_HALF_OUTPUT, 32'(c.halve));
        write_reg(tdg_pkg::CFG_INPUT_BASE, c.in_base);
        write_reg(tdg_pkg::CFG_OUTPUT_BASE, c.out_base);
        cfg_valid <= 1'b0;
        layers_loaded++;
    endtask

    // one task transfer, with an optional gap ahead of it
    task automatic drive_task(input bit rs);
        if (bursts_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            job_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        job_valid <= 1'b1;
        restart <= rs;
        @(posedge clk);
        while (job_stall) @(posedge clk);
        checker_h.take_task(rs);
        tasks_sent++;
        if (rs) restarts_sent++;
    endtask

    // drop valid and let every outstanding descriptor come back
    task automatic wait_idle();
        job_valid <= 1'b0;
        while (checker_h.pending() != 0) @(posedge clk);
    endtask

    function automatic int count_of(bit [tdg_pkg::COUNT_W-1:0] n);
        return (n == 0) ? 256 : int'(n);
    endfunction

    // mostly small layers so the walk reaches its end, now and then extremes
    function automatic layer_cfg_t random_layer();
        layer_cfg_t c;
        c.cols = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd1)
                                             : 10'($urandom_range(1, 40));
        c.rows = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd1)
                                             : 10'($urandom_range(1, 64));
        case ($urandom_range(0, 11))
            0:       c.trows = 10'd0;
            1:       c.trows = 10'd1;
            2:       c.trows = 10'd1023;
            default: c.trows = 10'($urandom_range(2, 20));
        endcase
        case ($urandom_range(0, 11))
            0:       c.tiles = 8'd0;
            1:       c.tiles = 8'd255;
            default: c.tiles = 8'($urandom_range(1, 5));
        endcase
        c.groups[7:0] = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                    : 8'($urandom_range(1, 3));
        c.groups[15:8] = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                     : 8'($urandom_range(1, 3));
        c.halve = 1'($urandom_range(0, 1));
        c.in_base = $urandom;
        c.out_base = $urandom;
        return c;
    endfunction

    // random descriptor stalls in bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (bursts_on && !quiet && $urandom_range(0, 7) == 0)
            begin
                desc_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                desc_stall <= 1'b0;
            end
        end
    end

    // descriptor monitor
    always @(posedge clk)
    begin
        descriptor_t got;
        if (rst_n && desc_valid && !desc_stall)
        begin
            got.recv_active = recv_active;
            got.recv_address = recv_address;
            got.recv_length = recv_length;
            got.send_active = send_active;
            got.send_address = send_address;
            got.send_length = send_length;
            got.last_task = last_task;
            checker_h.check_descriptor(got);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((job_valid && !job_stall) || (desc_valid && !desc_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        layer_cfg_t c;
        int n;
        int random_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a single-position layer, from reset state and after restart
        drive_task(1'b0);
        drive_task(1'b1);
        drive_task(1'b0);
        drive_task(1'b0);
        wait_idle();

        // largest frame, stride-2 output, bases near the top so addresses wrap
        c = '{cols: 10'd1023, rows: 10'd1023, trows: 10'd1023, tiles: 8'd3,
              groups: 16'h0102, halve: 1'b1, in_base: 32'hFFFF_FFF0,
              out_base: 32'hFFFF_FF00};
        load_layer(c);
        drive_task(1'b1);
        repeat (7) drive_task(1'b0);
        wait_idle();

        // zero tile rows, zero counts acting as 256, one-pixel frame
        c = '{cols: 10'd1, rows: 10'd1, trows: 10'd0, tiles: 8'd0,
              groups: 16'h0000, halve: 1'b0, in_base: 32'h0000_0000,
              out_base: 32'h8000_0000};
        load_layer(c);
        drive_task(1'b1);
        repeat (4) drive_task(1'b0);
        wait_idle();

        // remainder below the minimum residual rows, walk past the end
        c = '{cols: 10'd5, rows: 10'd13, trows: 10'd4, tiles: 8'd4,
              groups: 16'h0101, halve: 1'b0, in_base: 32'h1234_5678,
              out_base: 32'h0ABC_DEF0};
        load_layer(c);
        drive_task(1'b1);
        repeat (6) drive_task(1'b0);

        // random layers, mostly full walks with random stop points
        random_start = tasks_sent;
        while (tasks_sent - random_start < TASK_TARGET)
        begin
            quiet = (tasks_sent - random_start >= TASK_TARGET - QUIET_TAIL);
            bursts_on = ($urandom_range(0, 3) != 0);
            wait_idle();
            if ($urandom_range(0, 4) != 0)
                load_layer(random_layer());
            if ($urandom_range(0, 4) == 0)
            begin
                // loose mix of restarts and task-done transfers
                repeat ($urandom_range(8, 20)) drive_task($urandom_range(0, 3) == 0);
            end
            else
            begin
                n = count_of(checker_h.groups[7:0]) * count_of(checker_h.tiles) *
                    count_of(checker_h.groups[15:8]);
                if (n > LAYER_CAP) n = LAYER_CAP;
                drive_task(1'b1);
                repeat (n + $urandom_range(0, 2)) drive_task(1'b0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (checker_h.pending() != 0)
            checker_h.report($sformatf("%0d descriptors never arrived", checker_h.pending()));

        $display("ran %0d task transfers (%0d restarts) across %0d layer settings",
            tasks_sent, restarts_sent, layers_loaded);
        $display("checked %0d descriptors, %0d with receive enabled, %0d ending a layer",
            checker_h.checked, checker_h.recv_seen, checker_h.last_seen);
        if (checker_h.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
sv/tdg_pkg.sv
sv/tdg_mac.sv
sv/tdg_remainder.sv
sv/tile_dma_descriptor_generator.sv
sv/tdg_checker.sv
dv/tb_tile_dma_descriptor_generator.sv
